// ===== hw/rtl/float32_to_half_converter_macros.svh =====
// Assertion macros for the single to half precision converter.
// Used by the top level only; depends on nothing else.
`ifndef FLOAT32_TO_HALF_CONVERTER_MACROS_SVH
`define FLOAT32_TO_HALF_CONVERTER_MACROS_SVH

// Assert that an implication holds at every clock edge outside reset.
`define F2H_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert an implication that is checked even during reset.
`define F2H_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/f2h_pkg.sv =====
// Package for the single to half precision converter.
// Holds the shared stage payload types and format constants; no dependencies.
`timescale 1ns / 1ps

package f2h_pkg;

   localparam int SingleBias = 127;
   localparam int HalfBias   = 15;
   localparam int FracDrop   = 13;
   localparam logic [4:0] HalfExpMax = 5'd31;

   // Kind of result decided in the first stage.
   typedef enum logic [2:0] {
      KIND_ZERO   = 3'd0,
      KIND_INF    = 3'd1,
      KIND_NAN    = 3'd2,
      KIND_SUB    = 3'd3,
      KIND_NORMAL = 3'd4
   } kind_type;

   // Stage 1 to stage 2 payload: classified operand.
   typedef struct packed {
      logic        sign;
      kind_type    kind;
      logic [4:0]  shift;     // right shift amount of the significand
      logic [4:0]  half_exp;  // biased half exponent for normals
      logic [23:0] sig;       // significand with hidden bit, cleared for normals
   } class_type;

   // Stage 2 to stage 3 payload: shifted significand and round bits.
   typedef struct packed {
      logic        sign;
      kind_type    kind;
      logic [4:0]  half_exp;
      logic [10:0] quo;
      logic        round_up;
      logic [9:0]  payload;
   } shift_type;

endpackage

// ===== hw/rtl/f2h_classify.sv =====
// First converter stage: decodes the exponent and picks the result kind.
// Depends on f2h_pkg.
`timescale 1ns / 1ps

module f2h_classify (
   input  logic [31:0]         single_bits,
   output f2h_pkg::class_type  cls
);

   logic [7:0] rexp;
   logic [8:0] e_biased; // raw exponent, zero extended; half exponent is e_biased - 112

   always_comb begin
      rexp = single_bits[30:23];
      e_biased = {1'b0, rexp};
      cls.sign = single_bits[31];
      cls.sig = {1'b1, single_bits[22:0]};
      cls.shift = 5'd13;
      cls.half_exp = 5'd0;
      // Half exponent e = rexp - 112; subnormal when -10 <= e <= 0.
      if (rexp == 8'hFF) begin
         cls.kind = (single_bits[22:0] == 23'd0) ? f2h_pkg::KIND_INF : f2h_pkg::KIND_NAN;
      end else if (e_biased <= 9'd112) begin
         if (e_biased < 9'd102) begin
            cls.kind = f2h_pkg::KIND_ZERO;
         end else begin
            cls.kind = f2h_pkg::KIND_SUB;
            // Shift is 14 - e = 126 - rexp, in 14..24.
            cls.shift = 5'(9'd126 - e_biased);
         end
      end else if (e_biased >= 9'd143) begin
         cls.kind = f2h_pkg::KIND_INF;
      end else begin
         cls.kind = f2h_pkg::KIND_NORMAL;
         cls.half_exp = 5'(e_biased - 9'd112);
      end
      // Normals drop the hidden bit before rounding.
      if (cls.kind == f2h_pkg::KIND_NORMAL) begin
         cls.sig[23] = 1'b0;
      end
   end

endmodule

// ===== hw/rtl/f2h_shift.sv =====
// Second converter stage: shifts the significand and forms the round decision.
// Depends on f2h_pkg.
`timescale 1ns / 1ps

module f2h_shift (
   input  f2h_pkg::class_type  cls,
   output f2h_pkg::shift_type  shf
);

   logic [47:0] wide;
   logic [23:0] quo_full;
   logic [23:0] rem;
   logic        guard;
   logic        sticky;

   always_comb begin
      // Place the significand above 24 zero bits, then shift right.
      wide = {cls.sig, 24'd0} >> cls.shift;
      quo_full = wide[47:24];
      rem = wide[23:0];
      guard = rem[23];
      sticky = |rem[22:0];
      shf.sign = cls.sign;
      shf.kind = cls.kind;
      shf.half_exp = cls.half_exp;
      shf.quo = quo_full[10:0];
      shf.round_up = guard & (sticky | quo_full[0]);
      shf.payload = cls.sig[22:13];
   end

endmodule

// ===== hw/rtl/f2h_pack.sv =====
// Third converter stage: applies the rounding increment and packs the half.
// Depends on f2h_pkg.
`timescale 1ns / 1ps

module f2h_pack (
   input  f2h_pkg::shift_type  shf,
   output logic [15:0]         half_bits
);

   logic [11:0] rounded;
   logic [5:0]  exp_sum;

   always_comb begin
      rounded = {1'b0, shf.quo} + {11'd0, shf.round_up};
      exp_sum = {1'b0, shf.half_exp} + {5'd0, rounded[10]};
      half_bits = {shf.sign, 15'd0};
      case (shf.kind)
         f2h_pkg::KIND_INF: begin
            half_bits[14:10] = f2h_pkg::HalfExpMax;
         end
         f2h_pkg::KIND_NAN: begin
            half_bits[14:10] = f2h_pkg::HalfExpMax;
            half_bits[9:0] = (shf.payload == 10'd0) ? 10'd1 : shf.payload;
         end
         f2h_pkg::KIND_SUB: begin
            // A carry into bit 10 lands in the exponent field as the smallest normal.
            half_bits[14:0] = {4'd0, rounded[10:0]};
         end
         f2h_pkg::KIND_NORMAL: begin
            // Rounding carry bumps the exponent and clears the fraction.
            if (exp_sum >= 6'd31) begin
               half_bits[14:10] = f2h_pkg::HalfExpMax;
            end else begin
               half_bits[14:10] = exp_sum[4:0];
               half_bits[9:0] = rounded[9:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/float32_to_half_converter.sv =====
// Single to half precision converter: usage, pipeline and stall behavior.
// The slave channel (req_) carries one binary32 pattern per transaction in
// req_tdata. The master channel (rsp_) returns the binary16 pattern of the
// same value, rounded to nearest with ties to even, in rsp_tdata.
// Each transaction yields exactly one result transaction, in order.
// The pipeline has three register stages: classify, shift and round, pack.
// An accepted transaction passes through cls_ff, shf_ff and half_ff in order,
// and rsp_tvalid follows v3_ff. Throughput is one transaction per cycle while
// the receiver takes results, as every stage then takes a new one each cycle.
// All stages advance together whenever the output stage is empty or taken,
// so req_tready falls whenever the output stage holds a result that the
// receiver does not take; nothing is lost or repeated across a stall.
// Reset clears the stage valid bits; the payload registers are not reset.
`timescale 1ns / 1ps
`include "float32_to_half_converter_macros.svh"

module float32_to_half_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] single_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] half_bits
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   f2h_pkg::class_type cls_ff, cls_in;
   f2h_pkg::shift_type shf_ff, shf_in;
   logic [15:0]        half_ff, half_in;
   logic               advance;

   // The whole pipeline moves when the last stage can hand off.
   assign advance    = !v3_ff || rsp_tready;
   assign req_tready = advance;
   assign v1_in = req_tvalid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   f2h_classify u_classify (.single_bits(req_tdata), .cls(cls_in));
   f2h_shift    u_shift    (.cls(cls_ff), .shf(shf_in));
   f2h_pack     u_pack     (.shf(shf_ff), .half_bits(half_in));

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         cls_ff  <= cls_in;
         shf_ff  <= shf_in;
         half_ff <= half_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = half_ff;

   `F2H_ASSERT(a_stall_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result changed during stall")
   `F2H_ASSERT(a_ready_when_open, clock, reset, (!rsp_tvalid) |-> req_tready, "input blocked with empty output stage")
   `F2H_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for float32_to_half_converter: binary32 to binary16 rounding.
// Depends only on the converter RTL; expected half patterns come from a local predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int CycleLimit = 200000;
   localparam int PipeDepth  = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [15:0] expected_halves[$];
   int          mismatch_count = 0;
   int          halves_checked = 0;
   int          cycle_count = 0;
   bit          idle_enabled = 1'b1;
   bit          hold_receiver = 1'b0;
   int          hold_cycles = 0;

   float32_to_half_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Shift right with round to nearest, ties to even.
   function automatic logic [31:0] round_shift(logic [31:0] value, int amount);
      logic [31:0] quot;
      logic [31:0] rem;
      logic [31:0] halfway;
      if (amount == 0) begin
         return value;
      end
      quot = value >> amount;
      rem = value & ((32'd1 << amount) - 32'd1);
      halfway = 32'd1 << (amount - 1);
      if (rem > halfway || (rem == halfway && quot[0])) begin
         quot = quot + 32'd1;
      end
      return quot;
   endfunction

   // Predicted binary16 pattern of one binary32 pattern.
   function automatic logic [15:0] half_of_single(logic [31:0] single_bits);
      logic [15:0] sign_bit;
      logic [7:0]  raw_exp;
      logic [22:0] frac;
      logic [31:0] mant;
      logic [9:0]  payload;
      int          half_exp;
      sign_bit = {single_bits[31], 15'd0};
      raw_exp = single_bits[30:23];
      frac = single_bits[22:0];
      half_exp = int'(raw_exp) - 127 + 15;
      if (raw_exp == 8'hFF) begin
         payload = frac[22:13];
         if (frac != '0 && payload == '0) begin
            payload = 10'd1;
         end
         return sign_bit | 16'h7C00 | {6'd0, payload};
      end
      if (half_exp <= 0) begin
         if (half_exp < -10) begin
            return sign_bit;
         end
         mant = round_shift({8'd0, 1'b1, frac}, 14 - half_exp);
         return sign_bit | mant[15:0];
      end
      if (half_exp >= 31) begin
         return sign_bit | 16'h7C00;
      end
      mant = round_shift({9'd0, frac}, 13);
      if (mant == 32'd1024) begin
         mant = 0;
         half_exp++;
      end
      if (half_exp >= 31) begin
         return sign_bit | 16'h7C00;
      end
      return sign_bit | (16'(half_exp) << 10) | mant[15:0];
   endfunction

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("** float32_to_half_converter: FAILED **");
         $finish;
      end
   end

   // Result checker: each transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_halves.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result 0x%04h", rsp_tdata);
            end
         end else begin
            logic [15:0] want;
            want = expected_halves.pop_front();
            halves_checked++;
            if (rsp_tdata !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("half_bits mismatch: expected 0x%04h, actual 0x%04h", want,
                     rsp_tdata);
               end
            end
         end
      end
   end

   // Receiver ready: random stall bursts, or a long hold when requested.
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_receiver) begin
            rsp_tready <= 1'b0;
            hold_cycles++;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Send one pattern, with an optional random gap before it.
   task automatic send_single(input logic [31:0] single_bits);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= single_bits;
      expected_halves.push_back(half_of_single(single_bits));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_halves.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] make_single(bit s, int e, logic [22:0] f);
      return {s, 8'(e), f};
   endfunction

   // Zeros, infinities, NaN payloads, overflow and underflow edges, ties.
   task automatic test_special_values();
      send_single(32'h0000_0000);
      send_single(32'h8000_0000);
      send_single(32'h7F80_0000);
      send_single(32'hFF80_0000);
      send_single(32'h7FC0_0000);
      send_single(32'h7F80_0001);
      send_single(32'hFF80_2000);
      send_single(32'hFFFF_FFFF);
      send_single(32'h0000_0001);
      send_single(32'h807F_FFFF);
      send_single(32'h477F_E000);
      send_single(32'h477F_F000);
      send_single(32'h477F_EFFF);
      send_single(32'h7F7F_FFFF);
      send_single(32'h3880_0000);
      send_single(32'h387F_F000);
      send_single(32'h3380_0000);
      send_single(32'h3300_0000);
      send_single(32'h3300_0001);
      send_single(32'h3F80_1000);
      send_single(32'h3F80_3000);
      send_single(32'h3F80_1001);
      send_single(32'h33C0_0000);
      send_single(32'h3555_5555);
      drain_results();
   endtask

   // Random patterns, weighted toward the half range and rounding ties.
   task automatic test_random_patterns(input int count);
      logic [31:0] bits;
      logic [22:0] f;
      for (int i = 0; i < count; i++) begin
         f = 23'($urandom);
         case ($urandom_range(0, 5))
            0: bits = $urandom;
            1: bits = make_single(1'($urandom_range(0, 1)), $urandom_range(113, 142), f);
            2: bits = make_single(1'($urandom_range(0, 1)), $urandom_range(101, 113), f);
            3: bits = make_single(1'($urandom_range(0, 1)), $urandom_range(100, 143),
                  {f[22:13], 1'b1, 12'd0});
            4: bits = make_single(1'($urandom_range(0, 1)), 255, f);
            default: bits = make_single(1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? $urandom_range(143, 254) : $urandom_range(0, 100), f);
         endcase
         send_single(bits);
      end
   endtask

   // Receiver holds off while the sender keeps offering, filling the pipeline.
   task automatic test_backpressure();
      hold_receiver = 1'b1;
      fork
         begin
            while (hold_cycles < 40) @(negedge clock);
            hold_receiver = 1'b0;
         end
         test_random_patterns(20);
      join
      drain_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_values();
      test_random_patterns(300);
      test_backpressure();
      test_random_patterns(250);
      drain_results();
      idle_enabled = 1'b0;
      test_random_patterns(180);
      drain_results();
      repeat (PipeDepth + 5) @(negedge clock);
      $display("Checked %0d half results from directed edge cases and random patterns,",
         halves_checked);
      $display("with random stalls on both sides and one long receiver hold-off.");
      if (mismatch_count == 0 && expected_halves.size() == 0) begin
         $display("** float32_to_half_converter: PASSED **");
      end else begin
         $display("** float32_to_half_converter: FAILED **");
      end
      $finish;
   end

endmodule
